### design/pns_pkg.sv
// Shared types and constants for the nonpreemptive priority scheduler.
package pns_pkg;

    // Fixed field widths of the job and result beats.
    localparam int ID_W     = 8;
    localparam int BURST_W  = 16;
    localparam int OTIME_W  = 32;
    localparam int STATUS_W = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DISPATCHED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUT_ORDER  = 2'd2;

    // Status of one scan of the ready queue.
    typedef struct packed {
        logic done;
        logic found;
    } pick_stat_t;

endpackage

### design/pns_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pns_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/pns_pick.sv
// Queue scanner: walks the ready queue one entry per cycle and keeps the best job.
module pns_pick #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int TIME_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [QUEUE_DEPTH-1:0]              valid_vec,
    input  logic [pns_pkg::ID_W-1:0]            id_counter,
    output logic [$clog2(QUEUE_DEPTH)-1:0]      rd_addr,
    input  logic [pns_pkg::ID_W+PRIORITY_WIDTH+pns_pkg::BURST_W+TIME_WIDTH-1:0] rd_data,
    output pns_pkg::pick_stat_t                 stat,
    output logic [$clog2(QUEUE_DEPTH)-1:0]      best_idx,
    output logic [pns_pkg::ID_W-1:0]            best_id,
    output logic [pns_pkg::BURST_W-1:0]         best_burst,
    output logic [TIME_WIDTH-1:0]               best_arr
);

    localparam int AW       = $clog2(QUEUE_DEPTH);
    localparam int BURST_LO = TIME_WIDTH;
    localparam int PRIO_LO  = TIME_WIDTH + pns_pkg::BURST_W;
    localparam int ID_LO    = PRIO_LO + PRIORITY_WIDTH;
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    logic                          run_reg, run_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]                 cmp_idx_reg, cmp_idx_next;
    logic                          cmp_last_reg, cmp_last_next;
    logic                          found_reg, found_next;
    logic                          done_reg, done_next;
    logic [AW-1:0]                 bidx_reg, bidx_next;
    logic [pns_pkg::ID_W-1:0]      bid_reg, bid_next;
    logic [PRIORITY_WIDTH-1:0]     bprio_reg, bprio_next;
    logic [pns_pkg::BURST_W-1:0]   bburst_reg, bburst_next;
    logic [TIME_WIDTH-1:0]         barr_reg, barr_next;

    logic [pns_pkg::ID_W-1:0]      c_id;
    logic [PRIORITY_WIDTH-1:0]     c_prio;
    logic [pns_pkg::BURST_W-1:0]   c_burst;
    logic [TIME_WIDTH-1:0]         c_arr;
    logic [pns_pkg::ID_W-1:0]      age_c, age_b;
    logic                          better;

    // Unpack the entry coming out of the RAM.
    assign c_arr   = rd_data[TIME_WIDTH-1:0];
    assign c_burst = rd_data[BURST_LO +: pns_pkg::BURST_W];
    assign c_prio  = rd_data[PRIO_LO +: PRIORITY_WIDTH];
    assign c_id    = rd_data[ID_LO +: pns_pkg::ID_W];

    // The shared compare unit: priority, then arrival, then submission age.
    assign age_c  = id_counter - c_id;
    assign age_b  = id_counter - bid_reg;
    assign better = (c_prio < bprio_reg) ||
                    ((c_prio == bprio_reg) &&
                     ((c_arr < barr_reg) || ((c_arr == barr_reg) && (age_c > age_b))));

    // Scan sequencing and best-entry tracking.
    always_comb begin
        run_next      = run_reg;
        idx_next      = idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        cmp_last_next = 1'b0;
        found_next    = found_reg;
        done_next     = 1'b0;
        bidx_next     = bidx_reg;
        bid_next      = bid_reg;
        bprio_next    = bprio_reg;
        bburst_next   = bburst_reg;
        barr_next     = barr_reg;

        if (start) begin
            run_next   = 1'b1;
            idx_next   = '0;
            found_next = 1'b0;
        end else if (run_reg) begin
            cmp_vld_next  = 1'b1;
            cmp_idx_next  = idx_reg;
            cmp_last_next = (idx_reg == LAST_IDX);
            if (idx_reg == LAST_IDX) begin
                run_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmp_vld_reg) begin
            if (valid_vec[cmp_idx_reg] && (!found_reg || better)) begin
                found_next  = 1'b1;
                bidx_next   = cmp_idx_reg;
                bid_next    = c_id;
                bprio_next  = c_prio;
                bburst_next = c_burst;
                barr_next   = c_arr;
            end
            done_next = cmp_last_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg      <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            cmp_last_reg <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
        end else begin
            run_reg      <= run_next;
            cmp_vld_reg  <= cmp_vld_next;
            cmp_last_reg <= cmp_last_next;
            found_reg    <= found_next;
            done_reg     <= done_next;
            idx_reg      <= idx_next;
        end
    end

    // Payload registers of the current best entry.
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        bidx_reg    <= bidx_next;
        bid_reg     <= bid_next;
        bprio_reg   <= bprio_next;
        bburst_reg  <= bburst_next;
        barr_reg    <= barr_next;
    end

    assign rd_addr    = idx_reg;
    assign stat.done  = done_reg;
    assign stat.found = found_reg;
    assign best_idx   = bidx_reg;
    assign best_id    = bid_reg;
    assign best_burst = bburst_reg;
    assign best_arr   = barr_reg;

endmodule

### design/priority_nonpreemptive_scheduler_top.sv
// Top level of the nonpreemptive priority scheduler: sequencer, queue state and result register.
//
// Usage: one job is offered per beat on the s_ channel (arrival time, burst, priority,
// last_job). Each job beat causes zero or more result beats on the m_ channel: dispatches
// of queued jobs whose turn comes before the new arrival, a rejection if the job is out of
// order or the queue is full, and, for a job marked last_job, the dispatch of every queued
// job. m_last_result marks the final result beat caused by one job beat.
// Timing: the block takes one job at a time; s_ready is high only while the sequencer is
// idle. Each dispatch runs a scan that reads one queue entry per cycle from the RAM read
// port and compares it in the single compare unit.
// Reset (aresetn low, synchronous) empties the queue, clears the time and batch state and
// sets the next job number to 1. The queue RAM itself needs no clearing.
// Stalls: results go out through one output register; while it holds a result and m_ready is low,
// the sequencer holds before writing the next result, and no input beat is taken until it is done.
module priority_nonpreemptive_scheduler_top #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int TIME_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [31:0]                        s_arrival_time,
    input  logic [pns_pkg::BURST_W-1:0]        s_burst_time,
    input  logic [7:0]                         s_priority_req,
    input  logic                               s_last_job,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pns_pkg::ID_W-1:0]           m_job_id,
    output logic [pns_pkg::OTIME_W-1:0]        m_start_time,
    output logic [pns_pkg::OTIME_W-1:0]        m_end_time,
    output logic [pns_pkg::OTIME_W-1:0]        m_waiting_time,
    output logic [pns_pkg::OTIME_W-1:0]        m_turnaround_time,
    output logic [pns_pkg::STATUS_W-1:0]       m_status,
    output logic                               m_last_result
);

    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int ENTRY_W = pns_pkg::ID_W + PRIORITY_WIDTH + pns_pkg::BURST_W + TIME_WIDTH;
    localparam int ID_W    = pns_pkg::ID_W;
    localparam int OW      = pns_pkg::OTIME_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_PRE       = 4'd2;
    localparam logic [3:0] S_REJ_ORDER = 4'd3;
    localparam logic [3:0] S_REJ_FULL  = 4'd4;
    localparam logic [3:0] S_DRAIN     = 4'd5;
    localparam logic [3:0] S_SCAN      = 4'd6;
    localparam logic [3:0] S_CALC      = 4'd7;
    localparam logic [3:0] S_EMIT      = 4'd8;

    logic [3:0]                   state_reg, state_next;
    logic                         drain_reg, drain_next;
    logic [TIME_WIDTH-1:0]        clock_reg, clock_next;
    logic [ID_W-1:0]              id_reg, id_next;
    logic [TIME_WIDTH-1:0]        prev_reg, prev_next;
    logic                         batch_open_reg, batch_open_next;
    logic [QUEUE_DEPTH-1:0]       valid_reg, valid_next;
    logic                         m_valid_reg, m_valid_next;

    logic [TIME_WIDTH-1:0]        in_arr_reg, in_arr_next;
    logic [pns_pkg::BURST_W-1:0]  in_burst_reg, in_burst_next;
    logic [PRIORITY_WIDTH-1:0]    in_prio_reg, in_prio_next;
    logic                         in_last_reg, in_last_next;
    logic [TIME_WIDTH-1:0]        st_reg, st_next;
    logic [TIME_WIDTH-1:0]        en_reg, en_next;

    logic [ID_W-1:0]              o_id_reg, o_id_next;
    logic [OW-1:0]                o_start_reg, o_start_next;
    logic [OW-1:0]                o_end_reg, o_end_next;
    logic [OW-1:0]                o_wait_reg, o_wait_next;
    logic [OW-1:0]                o_turn_reg, o_turn_next;
    logic [pns_pkg::STATUS_W-1:0] o_status_reg, o_status_next;
    logic                         o_last_reg, o_last_next;

    logic                         q_empty, q_full, out_free, in_fire;
    logic [AW-1:0]                free_idx;
    logic                         ins_we;
    logic [ENTRY_W-1:0]           ins_data;
    logic                         pick_start;
    pns_pkg::pick_stat_t          pick_stat;
    logic [AW-1:0]                rd_addr;
    logic [ENTRY_W-1:0]           rd_data;
    logic [AW-1:0]                best_idx;
    logic [ID_W-1:0]              best_id;
    logic [pns_pkg::BURST_W-1:0]  best_burst;
    logic [TIME_WIDTH-1:0]        best_arr;
    logic [TIME_WIDTH:0]          end_sum;
    logic [TIME_WIDTH-1:0]        end_sat;

    assign q_empty  = ~|valid_reg;
    assign q_full   = &valid_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign ins_data = {id_reg, in_prio_reg, in_burst_reg, in_arr_reg};

    // Lowest free queue slot.
    always_comb begin
        free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = AW'(i);
            end
        end
    end

    // End time of the picked job, saturated to the time width.
    assign end_sum = {1'b0, clock_reg} + (TIME_WIDTH + 1)'(best_burst);
    assign end_sat = end_sum[TIME_WIDTH] ? '1 : end_sum[TIME_WIDTH-1:0];

    // Queue entry storage.
    pns_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (ins_we),
        .waddr (free_idx),
        .wdata (ins_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Best-job scanner.
    pns_pick #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .TIME_WIDTH     (TIME_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_pick (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (pick_start),
        .valid_vec  (valid_reg),
        .id_counter (id_reg),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .stat       (pick_stat),
        .best_idx   (best_idx),
        .best_id    (best_id),
        .best_burst (best_burst),
        .best_arr   (best_arr)
    );

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        drain_next      = drain_reg;
        clock_next      = clock_reg;
        id_next         = id_reg;
        prev_next       = prev_reg;
        batch_open_next = batch_open_reg;
        valid_next      = valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        in_arr_next     = in_arr_reg;
        in_burst_next   = in_burst_reg;
        in_prio_next    = in_prio_reg;
        in_last_next    = in_last_reg;
        st_next         = st_reg;
        en_next         = en_reg;
        o_id_next       = o_id_reg;
        o_start_next    = o_start_reg;
        o_end_next      = o_end_reg;
        o_wait_next     = o_wait_reg;
        o_turn_next     = o_turn_reg;
        o_status_next   = o_status_reg;
        o_last_next     = o_last_reg;
        ins_we          = 1'b0;
        pick_start      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    in_arr_next   = TIME_WIDTH'(s_arrival_time);
                    in_burst_next = s_burst_time;
                    in_prio_next  = PRIORITY_WIDTH'(s_priority_req);
                    in_last_next  = s_last_job;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (batch_open_reg && (in_arr_reg < prev_reg)) begin
                    state_next = S_REJ_ORDER;
                end else begin
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                if (!q_empty && (in_arr_reg > clock_reg)) begin
                    pick_start = 1'b1;
                    drain_next = 1'b0;
                    state_next = S_SCAN;
                end else begin
                    if (q_empty && (!batch_open_reg || (in_arr_reg > clock_reg))) begin
                        clock_next = in_arr_reg;
                    end
                    if (q_full) begin
                        state_next = S_REJ_FULL;
                    end else begin
                        ins_we                = 1'b1;
                        valid_next[free_idx]  = 1'b1;
                        id_next               = id_reg + 1'b1;
                        prev_next             = in_arr_reg;
                        batch_open_next       = 1'b1;
                        state_next            = in_last_reg ? S_DRAIN : S_IDLE;
                    end
                end
            end
            S_REJ_ORDER: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_id_next     = id_reg;
                    o_start_next  = '0;
                    o_end_next    = '0;
                    o_wait_next   = '0;
                    o_turn_next   = '0;
                    o_status_next = pns_pkg::STATUS_OUT_ORDER;
                    o_last_next   = !in_last_reg || q_empty;
                    state_next    = in_last_reg ? S_DRAIN : S_IDLE;
                end
            end
            S_REJ_FULL: begin
                // A full queue is never empty, so a last job always drains afterwards.
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_id_next     = id_reg;
                    o_start_next  = '0;
                    o_end_next    = '0;
                    o_wait_next   = '0;
                    o_turn_next   = '0;
                    o_status_next = pns_pkg::STATUS_QUEUE_FULL;
                    o_last_next   = !in_last_reg;
                    state_next    = in_last_reg ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (!q_empty) begin
                    pick_start = 1'b1;
                    drain_next = 1'b1;
                    state_next = S_SCAN;
                end else begin
                    clock_next      = '0;
                    prev_next       = '0;
                    batch_open_next = 1'b0;
                    id_next         = ID_W'(1);
                    state_next      = S_IDLE;
                end
            end
            S_SCAN: begin
                if (pick_stat.done) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                st_next              = clock_reg;
                en_next              = end_sat;
                clock_next           = end_sat;
                valid_next[best_idx] = 1'b0;
                state_next           = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_id_next     = best_id;
                    o_start_next  = OW'(st_reg);
                    o_end_next    = OW'(en_reg);
                    o_wait_next   = OW'(st_reg - best_arr);
                    o_turn_next   = OW'(en_reg - best_arr);
                    o_status_next = pns_pkg::STATUS_DISPATCHED;
                    if (drain_reg) begin
                        o_last_next = q_empty;
                        state_next  = S_DRAIN;
                    end else begin
                        // Nothing follows if the loop ends and the job is inserted silently.
                        o_last_next = !in_last_reg && (q_empty || (in_arr_reg <= clock_reg));
                        state_next  = S_PRE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            drain_reg      <= 1'b0;
            clock_reg      <= '0;
            id_reg         <= ID_W'(1);
            prev_reg       <= '0;
            batch_open_reg <= 1'b0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            drain_reg      <= drain_next;
            clock_reg      <= clock_next;
            id_reg         <= id_next;
            prev_reg       <= prev_next;
            batch_open_reg <= batch_open_next;
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        in_arr_reg   <= in_arr_next;
        in_burst_reg <= in_burst_next;
        in_prio_reg  <= in_prio_next;
        in_last_reg  <= in_last_next;
        st_reg       <= st_next;
        en_reg       <= en_next;
        o_id_reg     <= o_id_next;
        o_start_reg  <= o_start_next;
        o_end_reg    <= o_end_next;
        o_wait_reg   <= o_wait_next;
        o_turn_reg   <= o_turn_next;
        o_status_reg <= o_status_next;
        o_last_reg   <= o_last_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_job_id          = o_id_reg;
    assign m_start_time      = o_start_reg;
    assign m_end_time        = o_end_reg;
    assign m_waiting_time    = o_wait_reg;
    assign m_turnaround_time = o_turn_reg;
    assign m_status          = o_status_reg;
    assign m_last_result     = o_last_reg;

    // A scan is only started on a nonempty queue, so it must find a job.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pick_stat.done |-> pick_stat.found)
        else $error("queue scan finished without a job");

    // An insertion never overwrites a queued job.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ins_we |-> !valid_reg[free_idx])
        else $error("insertion into an occupied slot");

    // Queued jobs only exist inside an open batch.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (|valid_reg) |-> batch_open_reg)
        else $error("queued jobs outside an open batch");

    // Closing a batch returns time and job numbering to their start values.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN && q_empty) |=> (clock_reg == '0 && !batch_open_reg &&
                                               id_reg == ID_W'(1)))
        else $error("batch state not cleared after drain");

    // A dispatched job never ends before it starts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (en_reg >= st_reg))
        else $error("end time before start time");

endmodule

### dv/priority_nonpreemptive_scheduler_top_test.sv
// Self-checking testbench for the nonpreemptive priority scheduler top level.
module priority_nonpreemptive_scheduler_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int JOB_SLOTS     = 16;
    localparam int TIME_BITS     = 32;
    localparam int PRIO_BITS     = 8;
    localparam int RANDOM_ITEMS  = 190;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int QUIET_LIMIT   = 4000;

    // Golden schedule: mirrors the ready queue and keeps the results still owed by the block.
    class dispatch_scoreboard;
        typedef struct packed {
            logic [pns_pkg::ID_W-1:0]     job_id;
            logic [pns_pkg::OTIME_W-1:0]  start_time;
            logic [pns_pkg::OTIME_W-1:0]  end_time;
            logic [pns_pkg::OTIME_W-1:0]  waiting_time;
            logic [pns_pkg::OTIME_W-1:0]  turnaround_time;
            logic [pns_pkg::STATUS_W-1:0] status;
            logic                         last_result;
        } sched_result_t;

        bit [7:0]  slot_id [JOB_SLOTS];
        bit [7:0]  slot_prio [JOB_SLOTS];
        bit [15:0] slot_burst [JOB_SLOTS];
        bit [31:0] slot_arrival [JOB_SLOTS];
        bit        slot_busy [JOB_SLOTS];
        bit [31:0] now_t;
        bit [7:0]  next_id;
        bit [31:0] prev_arrival;
        bit        batch_open;
        sched_result_t due_results[$];
        int errors;

        function new();
            foreach (slot_busy[i]) slot_busy[i] = 1'b0;
            now_t = '0;
            next_id = 8'd1;
            prev_arrival = '0;
            batch_open = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function bit queue_is_empty();
            foreach (slot_busy[i]) if (slot_busy[i]) return 1'b0;
            return 1'b1;
        endfunction

        function void owe_result(bit [7:0] id, bit [31:0] st, bit [31:0] en, bit [31:0] wt,
                                 bit [31:0] ta, bit [1:0] code);
            sched_result_t r;
            r.job_id = id;
            r.start_time = st;
            r.end_time = en;
            r.waiting_time = wt;
            r.turnaround_time = ta;
            r.status = code;
            r.last_result = 1'b0;
            due_results.insert(due_results.size(), r);
        endfunction

        // Lowest priority value wins; then the earlier arrival; then the older job number.
        function int pick_job();
            int best;
            int i;
            bit [7:0] age_i, age_b;
            best = -1;
            for (i = 0; i < JOB_SLOTS; i++) begin
                if (!slot_busy[i]) continue;
                if (best < 0) begin
                    best = i;
                    continue;
                end
                age_i = next_id - slot_id[i];
                age_b = next_id - slot_id[best];
                if (slot_prio[i] < slot_prio[best] ||
                    (slot_prio[i] == slot_prio[best] &&
                     (slot_arrival[i] < slot_arrival[best] ||
                      (slot_arrival[i] == slot_arrival[best] && age_i > age_b))))
                    best = i;
            end
            return best;
        endfunction

        // Runs the chosen job to completion; the end time saturates at the top of the range.
        function void dispatch_next();
            int s;
            bit [32:0] sum;
            bit [31:0] fin;
            s = pick_job();
            sum = {1'b0, now_t} + 33'(slot_burst[s]);
            fin = sum[32] ? '1 : sum[31:0];
            owe_result(slot_id[s], now_t, fin, now_t - slot_arrival[s],
                       fin - slot_arrival[s], pns_pkg::STATUS_DISPATCHED);
            now_t = fin;
            slot_busy[s] = 1'b0;
        endfunction

        function void note_job(bit [31:0] arr, bit [15:0] burst, bit [7:0] prio, bit last);
            int owed_start;
            int slot;
            int i;
            owed_start = due_results.size();
            slot = -1;
            if (batch_open && arr < prev_arrival) begin
                owe_result(next_id, '0, '0, '0, '0, pns_pkg::STATUS_OUT_ORDER);
            end else begin
                while (!queue_is_empty() && arr > now_t) dispatch_next();
                if (queue_is_empty() && (!batch_open || arr > now_t)) now_t = arr;
                for (i = 0; i < JOB_SLOTS; i++) begin
                    if (!slot_busy[i]) begin
                        slot = i;
                        break;
                    end
                end
                if (slot < 0) begin
                    owe_result(next_id, '0, '0, '0, '0, pns_pkg::STATUS_QUEUE_FULL);
                end else begin
                    slot_id[slot] = next_id;
                    slot_prio[slot] = prio;
                    slot_burst[slot] = burst;
                    slot_arrival[slot] = arr;
                    slot_busy[slot] = 1'b1;
                    next_id = next_id + 8'd1;
                    prev_arrival = arr;
                    batch_open = 1'b1;
                end
            end
            // A last job empties the queue and closes the batch, rejected or not.
            if (last) begin
                while (!queue_is_empty()) dispatch_next();
                now_t = '0;
                prev_arrival = '0;
                batch_open = 1'b0;
                next_id = 8'd1;
            end
            if (due_results.size() > owed_start)
                due_results[due_results.size() - 1].last_result = 1'b1;
        endfunction

        function void compare_field(string name, bit [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [7:0] id, logic [31:0] st, logic [31:0] en,
                                   logic [31:0] wt, logic [31:0] ta, logic [1:0] code,
                                   logic last);
            sched_result_t want;
            if (due_results.size() == 0) begin
                $error("result beat with nothing owed: job_id %0h, code %0h", id, code);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("job_id", 32'(want.job_id), 32'(id));
            compare_field("start_time", want.start_time, st);
            compare_field("end_time", want.end_time, en);
            compare_field("waiting_time", want.waiting_time, wt);
            compare_field("turnaround_time", want.turnaround_time, ta);
            compare_field("status", 32'(want.status), 32'(code));
            compare_field("last_result", 32'(want.last_result), 32'(last));
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [31:0]                  s_arrival_time = '0;
    logic [pns_pkg::BURST_W-1:0]  s_burst_time = '0;
    logic [7:0]                   s_priority_req = '0;
    logic                         s_last_job = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [pns_pkg::ID_W-1:0]     m_job_id;
    logic [pns_pkg::OTIME_W-1:0]  m_start_time;
    logic [pns_pkg::OTIME_W-1:0]  m_end_time;
    logic [pns_pkg::OTIME_W-1:0]  m_waiting_time;
    logic [pns_pkg::OTIME_W-1:0]  m_turnaround_time;
    logic [pns_pkg::STATUS_W-1:0] m_status;
    logic                         m_last_result;

    dispatch_scoreboard sb = new();
    bit hold_req = 1'b0;
    bit gaps_on = 1'b1;
    int burst_left = 0;
    int random_items = 0;
    int quiet_cycles = 0;

    priority_nonpreemptive_scheduler_top #(
        .QUEUE_DEPTH(JOB_SLOTS),
        .TIME_WIDTH(TIME_BITS),
        .PRIORITY_WIDTH(PRIO_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_arrival_time(s_arrival_time),
        .s_burst_time(s_burst_time),
        .s_priority_req(s_priority_req),
        .s_last_job(s_last_job),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_job_id(m_job_id),
        .m_start_time(m_start_time),
        .m_end_time(m_end_time),
        .m_waiting_time(m_waiting_time),
        .m_turnaround_time(m_turnaround_time),
        .m_status(m_status),
        .m_last_result(m_last_result)
    );

    // 20 ns clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Beats are taken at the rising edge; an owed result is checked before a new job is noted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_job_id, m_start_time, m_end_time, m_waiting_time,
                                m_turnaround_time, m_status, m_last_result);
            if (s_valid && s_ready)
                sb.note_job(s_arrival_time, s_burst_time, s_priority_req, s_last_job);
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result sink: randomly chosen stall patterns, plus a long hold on request.
    initial begin : result_sink
        int mode;
        int left;
        int phase;
        mode = 0;
        left = 0;
        phase = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 150);
                end
                left--;
                phase++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 4) != 0);
                    default: m_ready <= (phase % 3 == 0);
                endcase
            end
        end
    end

    task automatic idle_cycles(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Offers one job beat and waits for it to be taken; with gaps on, each burst begins with a random gap.
    task automatic send_job(input bit [31:0] arr, input bit [15:0] burst,
                            input bit [7:0] prio, input bit last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if (gaps_on) idle_cycles($urandom_range(1, 7));
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_arrival_time <= arr;
        s_burst_time <= burst;
        s_priority_req <= prio;
        s_last_job <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // One batch of jobs, mostly in arrival order, with random content, closed by a last job.
    task automatic run_batch();
        longint unsigned arr;
        bit [31:0] a;
        bit [15:0] b;
        bit [7:0] p;
        int n_jobs;
        int burst_cap;
        int i;
        bit tie_prio;
        n_jobs = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 20);
        case ($urandom_range(0, 5))
            0: arr = $urandom;
            1: arr = 64'hFFFF_FFFF - $urandom_range(0, 200000);
            default: arr = $urandom_range(0, 2000);
        endcase
        burst_cap = ($urandom_range(0, 2) == 0) ? 600 : 40;
        tie_prio = ($urandom_range(0, 2) == 0);
        for (i = 0; i < n_jobs; i++) begin
            if (i > 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: ;
                    9: arr += $urandom_range(0, 100000);
                    default: arr += $urandom_range(1, 60);
                endcase
            end
            if (arr > 64'hFFFF_FFFF) arr = 64'hFFFF_FFFF;
            a = arr[31:0];
            // Now and then a job claims an arrival earlier than the one ahead of it.
            if (i > 0 && a != 0 && $urandom_range(0, 11) == 0) a = $urandom % a;
            b = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, burst_cap));
            p = tie_prio ? 8'($urandom_range(0, 3)) : 8'($urandom);
            send_job(a, b, p, i == n_jobs - 1);
            random_items++;
        end
    endtask

    initial begin : stimulus
        int batch_no;
        int i;
        batch_no = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Equal priorities and arrivals, an out-of-order job, then a jump forward and a drain.
        send_job(32'd5, 16'd3, 8'd7, 1'b0);
        send_job(32'd5, 16'd10, 8'd2, 1'b0);
        send_job(32'd5, 16'd1, 8'd2, 1'b0);
        send_job(32'd2, 16'd0, 8'd0, 1'b0);
        send_job(32'd40, 16'd4, 8'hFF, 1'b1);

        // End times saturate near the top of the time range; a rejected last job still drains.
        send_job(32'hFFFF_FFF0, 16'hFFFF, 8'h80, 1'b0);
        send_job(32'hFFFF_FFFF, 16'd5, 8'h01, 1'b0);
        send_job(32'd0, 16'd0, 8'd0, 1'b1);

        // Sixteen jobs at one arrival fill the queue; the next is refused and drains the rest.
        for (i = 0; i < JOB_SLOTS; i++)
            send_job(32'd100, (i == 0) ? 16'hFFFF : 16'(i * 3),
                     (i == 1) ? 8'hFF : 8'(i % 4), 1'b0);
        send_job(32'd100, 16'd1, 8'd0, 1'b1);

        // Random batches, with some bare noise jobs mixed in.
        while (random_items < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (batch_no == 3 || $urandom_range(0, 15) == 0) hold_req = 1'b1;
            if (batch_no == 6 || $urandom_range(0, 15) == 0) wait_for_results();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_job($urandom, 16'($urandom), 8'($urandom), 1'($urandom));
                    random_items++;
                end
            end else begin
                run_batch();
            end
            batch_no++;
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
